/* sv/cohesive_bond_damage_tracker_unit_defines.svh */
// Assertion macros for the cohesive bond damage tracker.
// Taken in by the top level; depends on nothing.
`ifndef COHESIVE_BOND_DAMAGE_TRACKER_UNIT_DEFINES_SVH
`define COHESIVE_BOND_DAMAGE_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CBDT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbdt check failed");

// Next-cycle implication, disabled while reset is held.
`define CBDT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbdt check failed");

`endif

/* sv/cbdt_pkg.sv */
// Shared types and constants of the cohesive bond damage tracker.
// Used by cbdt_serial_mul and cohesive_bond_damage_tracker_unit; no dependencies.
package cbdt_pkg;

    localparam int unsigned CBDT_NODE_COUNT = 1024;

    localparam int MUL_W      = 32;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 56;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] BOND_BONDED   = 2'd0;
    localparam logic [1:0] BOND_DAMAGING = 2'd1;
    localparam logic [1:0] BOND_FREE     = 2'd2;

    localparam logic [16:0] DMG_FULL = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_HEIGHT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_GAP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_STRESS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOND_STIFFNESS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_AREA      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_EVAL,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic [1:0]  bond;
        logic [16:0] damage;
        logic [31:0] released;
    } node_rec_t;

endpackage

/* sv/cbdt_serial_mul.sv */
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// Depends on cbdt_pkg for the operand width.
module cbdt_serial_mul import cbdt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic                 busy,
    output logic [2*MUL_W-1:0]   product
);

    localparam int CNT_W = $clog2(MUL_W);

    logic [MUL_W-1:0]   a_reg, a_next;
    logic [MUL_W-1:0]   b_reg, b_next;
    logic [2*MUL_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [MUL_W:0]     sum;

    always_comb begin
        sum       = {1'b0, acc_reg[2*MUL_W-1:MUL_W]} + {1'b0, (b_reg[0] ? a_reg : '0)};
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (load) begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = {sum, acc_reg[MUL_W-1:1]};
            b_next   = {1'b0, b_reg[MUL_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MUL_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

/* sv/cohesive_bond_damage_tracker_unit.sv */
// Cohesive bond damage tracker: per-node bond state, damage and release time.
// Depends on cbdt_pkg, cbdt_serial_mul and cohesive_bond_damage_tracker_unit_defines.svh.
//
// One word in, one word out. After reset the node store is cleared one entry per
// cycle, during which no word is taken (configuration writes still are). A free,
// inactive or out-of-range node skips the arithmetic; a bonded node runs the 32-bit
// bit-serial multipliers; a damaging node runs the multipliers and then, unless the
// increment saturates, a restoring divider that yields one quotient bit per cycle.
// A finished word waits in the output register while the next word is taken.

`include "cohesive_bond_damage_tracker_unit_defines.svh"

module cohesive_bond_damage_tracker_unit import cbdt_pkg::*; #(
    parameter int unsigned NODE_COUNT = CBDT_NODE_COUNT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // node_index[9:0], node_active[10], height[42:11], pull_force[74:43], zeros above
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // bond_state[1:0], damage_level[18:2], time_released[50:19], state_changed[51]
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    ctl_state_t state_reg, state_next;

    logic [31:0] floor_reg;
    logic [30:0] gap_cfg_reg, stress_cfg_reg, stiff_reg, area_reg;
    logic [31:0] dt_reg;

    logic [9:0]  idx_reg;
    logic        act_reg;
    logic [31:0] height_reg, pull_reg;
    node_rec_t   rec_reg;
    node_rec_t   new_rec_reg, new_rec_next;
    logic [31:0] sep_reg, sep_next;
    logic [31:0] mag_reg, mag_next;
    logic [62:0] rem_reg, rem_next;
    logic [15:0] q_reg, q_next;
    logic [16:0] inc_reg, inc_next;
    logic [3:0]  div_cnt_reg, div_cnt_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    logic        m_tvalid_reg, m_tvalid_next;
    node_rec_t   out_rec_reg;
    logic        out_chg_reg;

    node_rec_t   mem [NODE_COUNT];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    node_rec_t     mem_wdata;

    logic          accept;
    logic [16:0]   in_idx_ext, idx_ext;
    logic          in_range;
    logic          out_load;

    logic [30:0] fgap, tmax, area;
    logic [32:0] diff;
    logic [32:0] t_sum;

    logic              mul_load, mul_busy, busy0, busy1;
    logic [MUL_W-1:0]  m0_a, m0_b, m1_b;
    logic [2*MUL_W-1:0] p0, p1;

    logic        over_gap, over_spring, over_stress, bond_trip, num_ge;
    logic [62:0] rem_sh;
    logic        rem_ge;
    logic [17:0] d_sum;
    logic [33:0] gap5;
    logic        go_free;

    assign accept     = s_tvalid && s_tready;
    assign in_idx_ext = {7'b0, s_tdata[9:0]};
    assign idx_ext    = {7'b0, idx_reg};
    assign in_range   = idx_ext < 17'(NODE_COUNT);

    assign fgap = (gap_cfg_reg == '0) ? 31'd1 : gap_cfg_reg;
    assign tmax = (stress_cfg_reg == '0) ? 31'd1 : stress_cfg_reg;
    assign area = (area_reg == '0) ? 31'd1 : area_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg      <= '0;
            gap_cfg_reg    <= 31'h10000;
            stress_cfg_reg <= 31'h10000;
            stiff_reg      <= 31'h10000;
            area_reg       <= 31'h10000;
            dt_reg         <= 32'h10000;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FLOOR_HEIGHT:   floor_reg      <= cfg_wdata;
                CFG_RELEASE_GAP:    gap_cfg_reg    <= cfg_wdata[30:0];
                CFG_PEAK_STRESS:    stress_cfg_reg <= cfg_wdata[30:0];
                CFG_BOND_STIFFNESS: stiff_reg      <= cfg_wdata[30:0];
                CFG_NODE_AREA:      area_reg       <= cfg_wdata[30:0];
                CFG_TIME_STEP:      dt_reg         <= cfg_wdata;
                default: ;
            endcase
        end
    end

    cbdt_serial_mul u_mul_lhs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (mul_load),
        .a       (m0_a),
        .b       (m0_b),
        .busy    (busy0),
        .product (p0)
    );

    cbdt_serial_mul u_mul_rhs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (mul_load),
        .a       ({1'b0, tmax}),
        .b       (m1_b),
        .busy    (busy1),
        .product (p1)
    );

    assign mul_busy = busy0 | busy1;

    // Operand selection and compares
    always_comb begin
        diff     = {height_reg[31], height_reg} - {floor_reg[31], floor_reg};
        sep_next = diff[32] ? 32'd0 : diff[31:0];
        mag_next = pull_reg[31] ? (~pull_reg + 32'd1) : pull_reg;
        if (rec_reg.bond == BOND_BONDED) begin
            m0_a = {1'b0, stiff_reg};
            m0_b = sep_next;
            m1_b = {1'b0, area};
        end else begin
            m0_a = dt_reg;
            m0_b = mag_next;
            m1_b = {1'b0, fgap};
        end
        t_sum       = {1'b0, rec_reg.released} + {1'b0, dt_reg};
        over_gap    = sep_reg > {1'b0, fgap};
        over_spring = p0 > {17'b0, tmax, 16'b0};
        over_stress = {16'b0, mag_reg, 16'b0} > p1;
        bond_trip   = over_gap || over_spring || over_stress;
        num_ge      = p0 >= p1;
        rem_sh      = {rem_reg[61:0], 1'b0};
        rem_ge      = rem_sh >= {1'b0, p1[61:0]};
        d_sum       = {1'b0, rec_reg.damage} + {1'b0, inc_reg};
        gap5        = {3'b0, fgap} + {1'b0, fgap, 2'b0};
        go_free     = (d_sum >= 18'h10000) || ({2'b0, sep_reg} > gap5);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == AW'(NODE_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (in_range && act_reg &&
                    (rec_reg.bond == BOND_BONDED || rec_reg.bond == BOND_DAMAGING)) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL: begin
                if (!mul_busy) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (rec_reg.bond == BOND_BONDED) begin
                    state_next = ST_FINISH;
                end else if (num_ge) begin
                    state_next = ST_UPDATE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_cnt_reg == 4'd15) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Control outputs
    always_comb begin
        s_tready  = 1'b0;
        mul_load  = 1'b0;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = idx_ext[AW-1:0];
        mem_wdata = new_rec_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            ST_IDLE: s_tready = 1'b1;
            ST_PREP: begin
                mul_load = in_range && act_reg &&
                           (rec_reg.bond == BOND_BONDED || rec_reg.bond == BOND_DAMAGING);
            end
            ST_FINISH: begin
                out_load = !m_tvalid_reg || m_tready;
                mem_we   = out_load && in_range;
            end
            default: ;
        endcase
    end

    // Datapath next values
    always_comb begin
        new_rec_next  = new_rec_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        inc_next      = inc_reg;
        div_cnt_next  = div_cnt_reg;
        clr_cnt_next  = clr_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end
        case (state_reg)
            ST_CLEAR: clr_cnt_next = clr_cnt_reg + 1'b1;
            ST_PREP: begin
                new_rec_next = rec_reg;
                if (act_reg && rec_reg.bond == BOND_FREE) begin
                    new_rec_next.released = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
                end
            end
            ST_EVAL: begin
                if (rec_reg.bond == BOND_BONDED) begin
                    if (bond_trip) begin
                        new_rec_next.bond   = BOND_DAMAGING;
                        new_rec_next.damage = '0;
                    end
                end else begin
                    inc_next     = DMG_FULL;
                    rem_next     = p0[62:0];
                    q_next       = '0;
                    div_cnt_next = '0;
                end
            end
            ST_DIV: begin
                rem_next     = rem_ge ? (rem_sh - {1'b0, p1[61:0]}) : rem_sh;
                q_next       = {q_reg[14:0], rem_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                inc_next     = {1'b0, q_next};
            end
            ST_UPDATE: begin
                if (go_free) begin
                    new_rec_next.bond     = BOND_FREE;
                    new_rec_next.damage   = DMG_FULL;
                    new_rec_next.released = '0;
                end else begin
                    new_rec_next.damage = d_sum[16:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            div_cnt_reg  <= div_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg    <= s_tdata[9:0];
            act_reg    <= s_tdata[10];
            height_reg <= s_tdata[42:11];
            pull_reg   <= s_tdata[74:43];
        end
        if (state_reg == ST_PREP) begin
            sep_reg <= sep_next;
            mag_reg <= mag_next;
        end
        new_rec_reg <= new_rec_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        inc_reg     <= inc_next;
        if (out_load) begin
            out_rec_reg <= in_range ? new_rec_reg : '0;
            out_chg_reg <= in_range && (new_rec_reg.bond != rec_reg.bond);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            rec_reg <= mem[in_idx_ext[AW-1:0]];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, out_chg_reg, out_rec_reg.released,
                       out_rec_reg.damage, out_rec_reg.bond};

    `CBDT_ASSERT_IMPL(a_free_full, aclk, aresetn, m_tvalid_reg && out_rec_reg.bond == BOND_FREE, out_rec_reg.damage == DMG_FULL)
    `CBDT_ASSERT_IMPL(a_dmg_cap, aclk, aresetn, m_tvalid_reg, out_rec_reg.damage <= DMG_FULL)
    `CBDT_ASSERT_IMPL(a_out_src, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg) == ST_FINISH)
    `CBDT_ASSERT_NEXT(a_mul_run, aclk, aresetn, mul_load, mul_busy && state_reg == ST_MUL)

endmodule

/* dv/cohesive_bond_damage_tracker_unit_tb.sv */
// Self-checking testbench of cohesive_bond_damage_tracker_unit: a directed plan, then random phases.
// Keeps its own copy of the node store and registers; depends on cbdt_pkg and the unit itself.
module cohesive_bond_damage_tracker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cbdt_pkg::*;

    typedef struct packed {
        logic [31:0] pull;
        logic [31:0] height;
        logic        active;
        logic [9:0]  index;
    } node_word_t;

    typedef struct packed {
        logic        changed;
        logic [31:0] released;
        logic [16:0] damage;
        logic [1:0]  bond;
    } bond_result_t;

    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_CHECKED,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [31:0]          reg_val;
        node_word_t           w;
        bond_result_t         want;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic [1:0]         bond_mem   [CBDT_NODE_COUNT];
    logic [16:0]        damage_mem [CBDT_NODE_COUNT];
    logic [31:0]        freed_mem  [CBDT_NODE_COUNT];
    logic signed [31:0] floor_reg;
    logic [30:0]        gap_reg;
    logic [30:0]        peak_reg;
    logic [30:0]        stiff_reg;
    logic [30:0]        area_reg;
    logic [31:0]        step_reg;

    bond_result_t outstanding[$];
    plan_row_t    plan[$];
    int unsigned  err_count = 0;
    bit           quiet = 1'b0;

    cohesive_bond_damage_tracker_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report(string what);
        if (err_count < 200) begin
            $display("%0t mismatch: %s", $realtime, what);
        end
        err_count++;
    endtask

    function automatic bond_result_t update_node(node_word_t w);
        logic [1:0]   was;
        longint       diff;
        longint       pull_s;
        logic [63:0]  sep;
        logic [63:0]  mag;
        logic [63:0]  fgap;
        logic [63:0]  tmax;
        logic [63:0]  area;
        logic [63:0]  num;
        logic [63:0]  den;
        logic [63:0]  rem;
        logic [63:0]  t;
        logic [16:0]  inc;
        logic [17:0]  sum;
        int           b;
        bond_result_t r;
        was = bond_mem[w.index];
        diff = longint'($signed(w.height)) - longint'(floor_reg);
        sep = (diff > 0) ? 64'(diff) : 64'd0;
        pull_s = longint'($signed(w.pull));
        mag = (pull_s < 0) ? 64'(-pull_s) : 64'(pull_s);
        fgap = (gap_reg == 0) ? 64'd1 : 64'(gap_reg);
        tmax = (peak_reg == 0) ? 64'd1 : 64'(peak_reg);
        area = (area_reg == 0) ? 64'd1 : 64'(area_reg);
        if (w.active) begin
            case (was)
                BOND_BONDED: begin
                    if (sep > fgap || 64'(stiff_reg) * sep > (tmax << 16) ||
                        (mag << 16) > tmax * area) begin
                        bond_mem[w.index] = BOND_DAMAGING;
                        damage_mem[w.index] = '0;
                    end
                end
                BOND_DAMAGING: begin
                    num = mag * 64'(step_reg);
                    den = tmax * fgap;
                    if (num >= den) begin
                        inc = DMG_FULL;
                    end else begin
                        rem = num;
                        inc = '0;
                        for (b = 0; b < 16; b++) begin
                            rem = rem << 1;
                            inc = inc << 1;
                            if (rem >= den) begin
                                rem = rem - den;
                                inc[0] = 1'b1;
                            end
                        end
                    end
                    sum = 18'(damage_mem[w.index]) + 18'(inc);
                    if (sum > 18'(DMG_FULL)) begin
                        sum = 18'(DMG_FULL);
                    end
                    damage_mem[w.index] = sum[16:0];
                    if (sum >= 18'(DMG_FULL) || sep > 64'd5 * fgap) begin
                        bond_mem[w.index] = BOND_FREE;
                        damage_mem[w.index] = DMG_FULL;
                        freed_mem[w.index] = '0;
                    end
                end
                BOND_FREE: begin
                    t = 64'(freed_mem[w.index]) + 64'(step_reg);
                    freed_mem[w.index] = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
                end
                default: ;
            endcase
        end
        r.bond = bond_mem[w.index];
        r.damage = damage_mem[w.index];
        r.released = freed_mem[w.index];
        r.changed = (bond_mem[w.index] != was);
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_FLOOR_HEIGHT:   floor_reg = val;
            CFG_RELEASE_GAP:    gap_reg = val[30:0];
            CFG_PEAK_STRESS:    peak_reg = val[30:0];
            CFG_BOND_STIFFNESS: stiff_reg = val[30:0];
            CFG_NODE_AREA:      area_reg = val[30:0];
            CFG_TIME_STEP:      step_reg = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // drop valid, hold until every word is back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic send_word(node_word_t w, logic checked, bond_result_t want);
        int           gap;
        bond_result_t predicted;
        gap = quiet ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'(w);
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = update_node(w);
        outstanding.insert(outstanding.size(), checked ? want : predicted);
    endtask

    function automatic logic [31:0] pick_reg(logic [31:0] lo_end, logic [31:0] hi_end,
                                             int unsigned lo, int unsigned hi);
        case ($urandom_range(0, 7))
            0: return lo_end;
            1: return hi_end;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    task automatic retune();
        drain();
        write_reg(CFG_FLOOR_HEIGHT,   pick_reg(32'h8000_0000, 32'h7FFF_FFFF, 0, 1 << 21));
        write_reg(CFG_RELEASE_GAP,    pick_reg(32'h0, 32'h7FFF_FFFF, 1 << 12, 1 << 18));
        write_reg(CFG_PEAK_STRESS,    pick_reg(32'h0, 32'h7FFF_FFFF, 1 << 12, 1 << 18));
        write_reg(CFG_BOND_STIFFNESS, pick_reg(32'h0, 32'h7FFF_FFFF, 0, 1 << 18));
        write_reg(CFG_NODE_AREA,      pick_reg(32'h0, 32'h7FFF_FFFF, 1 << 12, 1 << 18));
        write_reg(CFG_TIME_STEP,      pick_reg(32'h0, 32'hFFFF_FFFF, 1 << 10, 1 << 15));
    endtask

    // mostly live updates on a small group of nodes, gaps and pulls near the limits
    function automatic node_word_t random_word(int unsigned base);
        node_word_t w;
        longint     fgap;
        longint     thr;
        longint     off;
        longint     hv;
        longint     mv;
        fgap = (gap_reg == 0) ? 64'sd1 : longint'(gap_reg);
        thr = ((peak_reg == 0) ? 64'sd1 : longint'(peak_reg)) *
              ((area_reg == 0) ? 64'sd1 : longint'(area_reg));
        thr = thr >>> 16;
        if (thr > 64'sd1073741824) begin
            thr = 64'sd1073741824;
        end
        w.index = 10'(base + $urandom_range(0, 15));
        w.active = 1'b1;
        w.height = $urandom;
        w.pull = $urandom;
        case ($urandom_range(0, 9))
            0: begin
                w.index = 10'($urandom);
                w.active = 1'($urandom);
                return w;
            end
            1: begin
                w.active = 1'b0;
                return w;
            end
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0: off = -longint'($urandom_range(0, 1 << 20));
            1: off = longint'($urandom_range(0, 32'(fgap)));
            2: off = fgap - 1 + longint'($urandom_range(0, 2));
            3: off = fgap * longint'($urandom_range(1, 5)) - longint'($urandom_range(0, 1));
            4: off = 5 * fgap - 1 + longint'($urandom_range(0, 2));
            default: off = 5 * fgap + longint'($urandom_range(0, 1 << 20));
        endcase
        hv = longint'(floor_reg) + off;
        if (hv > 64'sd2147483647) begin
            hv = 64'sd2147483647;
        end
        if (hv < -64'sd2147483648) begin
            hv = -64'sd2147483648;
        end
        w.height = 32'(hv);
        case ($urandom_range(0, 3))
            0: mv = longint'($urandom_range(0, 32'(thr / 4)));
            1: mv = thr - 1 + longint'($urandom_range(0, 2));
            2: mv = longint'($urandom_range(0, 32'(2 * thr)));
            default: mv = longint'($urandom_range(0, 32'h8000_0000));
        endcase
        if (mv > 64'sd2147483648) begin
            mv = 64'sd2147483648;
        end
        if (mv < 0) begin
            mv = 0;
        end
        if ($urandom_range(0, 1) == 1) begin
            mv = -mv;
        end
        w.pull = 32'(mv);
        return w;
    endfunction

    function automatic plan_row_t word_row(logic [9:0] i, logic a, logic [31:0] h,
                                           logic [31:0] p);
        plan_row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.w.index = i;
        r.w.active = a;
        r.w.height = h;
        r.w.pull = p;
        return r;
    endfunction

    function automatic plan_row_t check_row(logic [9:0] i, logic a, logic [31:0] h,
                                            logic [31:0] p, logic [1:0] bnd, logic [16:0] dmg,
                                            logic [31:0] rel, logic chg);
        plan_row_t r;
        r = word_row(i, a, h, p);
        r.kind = ROW_CHECKED;
        r.want.bond = bnd;
        r.want.damage = dmg;
        r.want.released = rel;
        r.want.changed = chg;
        return r;
    endfunction

    function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        plan_row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic void add_row(plan_row_t r);
        plan.insert(plan.size(), r);
    endfunction

    initial begin
        int           stall;
        bond_result_t got;
        bond_result_t want;
        wait (aresetn === 1'b1);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got = m_tdata[$bits(bond_result_t)-1:0];
            if (outstanding.size() == 0) begin
                report($sformatf("result word %h with nothing outstanding", m_tdata));
            end else begin
                want = outstanding.pop_front();
                if (got.bond !== want.bond)
                    report($sformatf("bond_state %0d, want %0d", got.bond, want.bond));
                if (got.damage !== want.damage)
                    report($sformatf("damage_level %0h, want %0h", got.damage, want.damage));
                if (got.released !== want.released)
                    report($sformatf("time_released %0h, want %0h", got.released,
                                     want.released));
                if (got.changed !== want.changed)
                    report($sformatf("state_changed %0b, want %0b", got.changed, want.changed));
            end
        end
    end

    initial begin
        int          n;
        int          phase;
        int          k;
        int unsigned base;
        for (n = 0; n < CBDT_NODE_COUNT; n++) begin
            bond_mem[n] = BOND_BONDED;
            damage_mem[n] = '0;
            freed_mem[n] = '0;
        end
        floor_reg = '0;
        gap_reg = 31'h10000;
        peak_reg = 31'h10000;
        stiff_reg = 31'h10000;
        area_reg = 31'h10000;
        step_reg = 32'h10000;

        add_row(check_row(10'd0, 1'b0, 32'h0, 32'h0, BOND_BONDED, 17'd0, 32'h0, 1'b0));
        add_row(check_row(10'd1023, 1'b1, 32'h0, 32'h0, BOND_BONDED, 17'd0, 32'h0, 1'b0));
        add_row(check_row(10'd1023, 1'b1, 32'h7FFF_FFFF, 32'h0,
                          BOND_DAMAGING, 17'd0, 32'h0, 1'b1));
        add_row(check_row(10'd1023, 1'b1, 32'h0, 32'h8000_0000,
                          BOND_FREE, DMG_FULL, 32'h0, 1'b1));
        add_row(check_row(10'd1023, 1'b1, 32'h0, 32'h0,
                          BOND_FREE, DMG_FULL, 32'h10000, 1'b0));
        add_row(check_row(10'd1023, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          BOND_FREE, DMG_FULL, 32'h10000, 1'b0));
        add_row(check_row(10'd512, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
                          BOND_DAMAGING, 17'd0, 32'h0, 1'b1));
        add_row(check_row(10'd512, 1'b1, 32'h0005_0001, 32'h0,
                          BOND_FREE, DMG_FULL, 32'h0, 1'b1));
        add_row(check_row(10'd256, 1'b1, 32'h0, 32'h7FFF_FFFF,
                          BOND_DAMAGING, 17'd0, 32'h0, 1'b1));
        add_row(check_row(10'd256, 1'b1, 32'h0005_0000, 32'h0,
                          BOND_DAMAGING, 17'd0, 32'h0, 1'b0));
        add_row(check_row(10'd256, 1'b1, 32'h0, 32'h0000_4000,
                          BOND_DAMAGING, 17'd16384, 32'h0, 1'b0));
        add_row(check_row(10'd256, 1'b1, 32'h0, 32'hFFFF_C000,
                          BOND_DAMAGING, 17'd32768, 32'h0, 1'b0));
        add_row(check_row(10'd2, 1'b1, 32'h0001_0000, 32'h0001_0000,
                          BOND_BONDED, 17'd0, 32'h0, 1'b0));
        add_row(check_row(10'd2, 1'b1, 32'h0001_0001, 32'h0,
                          BOND_DAMAGING, 17'd0, 32'h0, 1'b1));
        add_row(word_row(10'd2, 1'b1, 32'h0, 32'h0000_7FFF));
        add_row(reg_row(CFG_TIME_STEP, 32'hFFFF_FFFF));
        add_row(check_row(10'd1023, 1'b1, 32'h0, 32'h0,
                          BOND_FREE, DMG_FULL, 32'hFFFF_FFFF, 1'b0));
        add_row(reg_row(CFG_RELEASE_GAP, 32'h0));
        add_row(reg_row(CFG_PEAK_STRESS, 32'h0));
        add_row(reg_row(CFG_NODE_AREA, 32'h0));
        add_row(reg_row(CFG_BOND_STIFFNESS, 32'h0));
        add_row(word_row(10'd3, 1'b1, 32'h0, 32'h1));
        add_row(word_row(10'd3, 1'b1, 32'h0, 32'h1));
        add_row(word_row(10'd4, 1'b1, 32'h1, 32'h0));
        add_row(word_row(10'd4, 1'b1, 32'h2, 32'h0));
        add_row(reg_row(CFG_FLOOR_HEIGHT, 32'h8000_0000));
        add_row(reg_row(CFG_RELEASE_GAP, 32'h7FFF_FFFF));
        add_row(reg_row(CFG_PEAK_STRESS, 32'h7FFF_FFFF));
        add_row(reg_row(CFG_NODE_AREA, 32'h7FFF_FFFF));
        add_row(reg_row(CFG_BOND_STIFFNESS, 32'h7FFF_FFFF));
        add_row(reg_row(CFG_TIME_STEP, 32'h0));
        add_row(word_row(10'd5, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000));
        add_row(word_row(10'd5, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000));
        add_row(word_row(10'd5, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000));
        add_row(reg_row(CFG_FLOOR_HEIGHT, 32'h7FFF_FFFF));
        add_row(word_row(10'd6, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF));

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_REG) begin
                drain();
                write_reg(plan[n].reg_idx, plan[n].reg_val);
            end else begin
                send_word(plan[n].w, plan[n].kind == ROW_CHECKED, plan[n].want);
            end
        end

        for (phase = 0; phase < 8; phase++) begin
            retune();
            base = $urandom_range(0, CBDT_NODE_COUNT - 16);
            for (k = 0; k < 250; k++) begin
                if (k % 50 == 0) begin
                    quiet = ($urandom_range(0, 3) == 0);
                end
                if (phase == 2 && k == 125) begin
                    drain();
                end
                send_word(random_word(base), 1'b0, '0);
            end
        end
        quiet = 1'b0;
        drain();
        repeat (60) @(posedge aclk);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
